// File: hw/rtl/iss_pkg.sv
// Package for the interval schedule select block.
// Holds the capacity, widths and the transfer record between front and back.
`default_nettype none
package iss_pkg;
   localparam int unsigned Capacity = 64;
   localparam int unsigned IdxW = $clog2(Capacity);
   localparam int unsigned CntW = $clog2(Capacity + 1);

   typedef struct packed {
      logic signed [31:0] start_time;
      logic signed [31:0] end_time;
      logic               last_item;
   } item_type;
endpackage
`default_nettype wire

// File: hw/rtl/iss_front.sv
// Front end: accepts items and passes them through a two-entry queue.
// Depends on iss_pkg.
`default_nettype none
module iss_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_start,
   input  wire iss_pkg::item_type req_item,
   output logic                   req_busy,
   output logic                   q_valid,
   output iss_pkg::item_type      q_item,
   input  wire logic              q_pop
);
   import iss_pkg::*;

   item_type  buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push;

   // a last item blocks further input until the back end pops it from the queue
   logic       hold_ff, hold_in;

   assign push     = req_start && !req_busy;
   assign req_busy = (cnt_ff == 2'd2) || hold_ff;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_item   = buf_ff[rd_ff];

   always_comb begin
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, q_pop};
      hold_in = hold_ff;
      if (push && req_item.last_item) hold_in = 1'b1;
      if (q_pop && q_item.last_item) hold_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         hold_ff <= hold_in;
         if (push) wr_ff <= !wr_ff;
         if (q_pop) rd_ff <= !rd_ff;
      end
      if (push) buf_ff[wr_ff] <= req_item;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && req_item.last_item) |=> req_busy)
      else $error("input open after last item");
endmodule
`default_nettype wire

// File: hw/rtl/iss_back.sv
// Back end: insertion-sort chain of registers, then a greedy walk that emits.
// Depends on iss_pkg.
`default_nettype none
module iss_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire iss_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output logic signed [31:0]     rsp_chosen_start,
   output logic signed [31:0]     rsp_chosen_end,
   output logic                   rsp_final_choice,
   output logic                   rsp_overflowed
);
   import iss_pkg::*;

   typedef enum logic [1:0] { LOAD, EMIT, FLUSH } state_type;

   state_type          state_ff;
   logic signed [31:0] s_ff [Capacity];
   logic signed [31:0] e_ff [Capacity];
   logic [CntW-1:0]    n_ff;
   logic [IdxW-1:0]    pos_ff;
   logic               drop_ff;
   logic signed [31:0] pend_s_ff;
   logic signed [31:0] pend_e_ff;
   logic               first_ff;
   logic [Capacity-1:0] gt;
   logic               take, tail;

   assign q_pop = q_valid && (state_ff == LOAD);

   // slot i holds a larger end than the new one: shift it up
   always_comb begin
      for (int i = 0; i < Capacity; i++) begin
         gt[i] = (CntW'(i) < n_ff) && (e_ff[i] > q_item.end_time);
      end
   end

   // chain head against the end of the interval taken last
   assign take = first_ff || !(s_ff[0] < pend_e_ff);
   assign tail = ({1'b0, pos_ff} + CntW'(1)) == n_ff;

   // a take is held in the pending registers until the next take, so the final one can be marked in the flush state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= LOAD;
         n_ff        <= '0;
         drop_ff     <= 1'b0;
         pos_ff      <= '0;
         first_ff    <= 1'b1;
         rsp_strobe  <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            LOAD: begin
               if (q_pop) begin
                  if (n_ff < CntW'(Capacity)) begin
                     for (int i = 0; i < Capacity; i++) begin
                        if (i > 0 && gt[(i + Capacity - 1) % Capacity]) begin
                           s_ff[i] <= s_ff[(i + Capacity - 1) % Capacity];
                           e_ff[i] <= e_ff[(i + Capacity - 1) % Capacity];
                        end else if (gt[i] || CntW'(i) == n_ff) begin
                           s_ff[i] <= q_item.start_time;
                           e_ff[i] <= q_item.end_time;
                        end
                     end
                     n_ff <= n_ff + 1'b1;
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (q_item.last_item) begin
                     state_ff <= EMIT;
                     pos_ff   <= '0;
                     first_ff <= 1'b1;
                     if (n_ff < CntW'(Capacity)) rsp_overflowed <= drop_ff;
                     else rsp_overflowed <= 1'b1;
                  end
               end
            end
            EMIT: begin
               if (take) begin
                  if (!first_ff) begin
                     rsp_strobe       <= 1'b1;
                     rsp_chosen_start <= pend_s_ff;
                     rsp_chosen_end   <= pend_e_ff;
                     rsp_final_choice <= 1'b0;
                  end
                  pend_s_ff <= s_ff[0];
                  pend_e_ff <= e_ff[0];
                  first_ff  <= 1'b0;
               end
               for (int i = 0; i + 1 < Capacity; i++) begin
                  s_ff[i] <= s_ff[i + 1];
                  e_ff[i] <= e_ff[i + 1];
               end
               if (tail) begin
                  state_ff <= FLUSH;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            FLUSH: begin
               rsp_strobe       <= 1'b1;
               rsp_chosen_start <= pend_s_ff;
               rsp_chosen_end   <= pend_e_ff;
               rsp_final_choice <= 1'b1;
               state_ff         <= LOAD;
               n_ff             <= '0;
               drop_ff          <= 1'b0;
               pos_ff           <= '0;
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) n_ff <= CntW'(Capacity))
      else $error("held count beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != LOAD) |-> !q_pop)
      else $error("load during emit");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != LOAD) |-> (n_ff != '0))
      else $error("emit with empty store");
endmodule
`default_nettype wire

// File: hw/rtl/interval_schedule_select_top.sv
// Top level of the interval schedule select block.
// Instantiates iss_front and iss_back; depends on iss_pkg.
//
// Usage: drive req_start_time, req_end_time, req_last_item with start
// high; the item is transferred at an edge where busy is low. Loading
// sorts each item into a register chain (insertion by end time,
// stable). An item marked last closes the set: the back end walks the
// chain, one entry per cycle, then flushes the held choice. During the
// walk busy drops once the last item has left the queue, and up to two
// items of the next set are queued.
// Each chosen interval appears for one cycle with rsp_strobe;
// rsp_final_choice marks the last one, rsp_overflowed flags dropped items.
// Items past 64 held are dropped. The receiver cannot stall. Reset
// (synchronous, active high) empties the store and the queue.
`default_nettype none
module interval_schedule_select_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic signed [31:0] req_start_time,
   input  wire logic signed [31:0] req_end_time,
   input  wire logic          req_last_item,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_chosen_start,
   output logic signed [31:0] rsp_chosen_end,
   output logic               rsp_final_choice,
   output logic               rsp_overflowed
);
   import iss_pkg::*;

   item_type req_item, q_item;
   logic     q_valid, q_pop;

   assign req_item = '{start_time: req_start_time, end_time: req_end_time,
                       last_item: req_last_item};

   iss_front u_front (
      .clock, .reset, .req_start(start), .req_item, .req_busy(busy),
      .q_valid, .q_item, .q_pop
   );

   iss_back u_back (
      .clock, .reset, .q_valid, .q_item, .q_pop,
      .rsp_strobe, .rsp_chosen_start, .rsp_chosen_end,
      .rsp_final_choice, .rsp_overflowed
   );
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for interval_schedule_select_top.
// Drives interval sets, predicts the earliest-finish selection and compares
// each chosen interval; depends on iss_pkg and the RTL only.
`default_nettype none
module testbench;
   import iss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] s;
      logic signed [31:0] e;
      logic               fin;
      logic               ovf;
   } choice_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_start_time = '0;
   logic signed [31:0] req_end_time = '0;
   logic req_last_item = 1'b0;
   logic rsp_strobe;
   logic signed [31:0] rsp_chosen_start;
   logic signed [31:0] rsp_chosen_end;
   logic rsp_final_choice;
   logic rsp_overflowed;

   item_type pending_items[$];
   choice_type expected_choices[$];
   int mismatches = 0;
   int sets_done = 0;
   int choices_seen = 0;
   int overflow_sets = 0;
   int gap_left = 0;
   int burst_left = 0;
   bit hold_off = 1'b0;

   logic signed [31:0] held_s[$];
   logic signed [31:0] held_e[$];
   bit dropped = 1'b0;

   always #2 clock = ~clock;

   interval_schedule_select_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_time(req_start_time), .req_end_time(req_end_time),
      .req_last_item(req_last_item), .rsp_strobe(rsp_strobe),
      .rsp_chosen_start(rsp_chosen_start), .rsp_chosen_end(rsp_chosen_end),
      .rsp_final_choice(rsp_final_choice), .rsp_overflowed(rsp_overflowed)
   );

   // stable insertion sort by end, then greedy pick
   task automatic select_schedule(input item_type it);
      int n;
      int j;
      int first_pick;
      logic signed [31:0] ks, ke, prev_end;
      choice_type c;
      if (held_s.size() < Capacity) begin
         held_s.push_back(it.start_time);
         held_e.push_back(it.end_time);
      end else begin
         dropped = 1'b1;
      end
      if (!it.last_item) return;
      n = held_s.size();
      for (int i = 1; i < n; i++) begin
         ks = held_s[i];
         ke = held_e[i];
         j = i;
         while (j > 0 && ke < held_e[j-1]) begin
            held_s[j] = held_s[j-1];
            held_e[j] = held_e[j-1];
            j--;
         end
         held_s[j] = ks;
         held_e[j] = ke;
      end
      first_pick = expected_choices.size();
      prev_end = '0;
      for (int i = 0; i < n; i++) begin
         if (i == 0 || !(held_s[i] < prev_end)) begin
            c.s = held_s[i];
            c.e = held_e[i];
            c.fin = 1'b0;
            c.ovf = dropped;
            prev_end = held_e[i];
            expected_choices.push_back(c);
         end
      end
      if (expected_choices.size() > first_pick)
         expected_choices[expected_choices.size()-1].fin = 1'b1;
      if (dropped) overflow_sets++;
      sets_done++;
      held_s.delete();
      held_e.delete();
      dropped = 1'b0;
   endtask

   function automatic logic signed [31:0] rand_time(input int mode);
      case (mode)
         0: return $urandom_range(0, 60);
         1: return 32'sh7FFF_FFF0 + $urandom_range(0, 15);
         2: return 32'sh8000_0000 + $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(input logic signed [31:0] s, input logic signed [31:0] e,
                           input logic last);
      item_type it;
      it.start_time = s;
      it.end_time = e;
      it.last_item = last;
      pending_items.push_back(it);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            select_schedule('{req_start_time, req_end_time, req_last_item});
            void'(pending_items.pop_front());
         end
         if (pending_items.size() == 0 || hold_off) begin
            start <= 1'b0;
         end else if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_start_time <= pending_items[0].start_time;
            req_end_time <= pending_items[0].end_time;
            req_last_item <= pending_items[0].last_item;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Note: the driver presents the head item while start is high; the head is
   // popped only once the transfer happens, so the ports match pending_items[0].
   always @(posedge clock) begin
      choice_type c;
      if (!reset && rsp_strobe) begin
         choices_seen++;
         if (expected_choices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected choice start=%0d end=%0d", rsp_chosen_start,
                        rsp_chosen_end);
         end else begin
            c = expected_choices.pop_front();
            if (c.s !== rsp_chosen_start || c.e !== rsp_chosen_end ||
                c.fin !== rsp_final_choice || c.ovf !== rsp_overflowed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("choice mismatch exp %0d %0d f%0b o%0b got %0d %0d f%0b o%0b",
                           c.s, c.e, c.fin, c.ovf, rsp_chosen_start, rsp_chosen_end,
                           rsp_final_choice, rsp_overflowed);
            end
         end
      end
   end

   initial begin
      int n;
      int mode;
      int base;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, single set, equal ends, nesting
      add_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
      add_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
      add_item(5, 10, 1'b0);
      add_item(1, 10, 1'b0);
      add_item(10, 10, 1'b0);
      add_item(0, 3, 1'b0);
      add_item(3, 6, 1'b1);
      add_item(-5, -1, 1'b0);
      add_item(-1, 0, 1'b0);
      add_item(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      add_item(-2, 4, 1'b1);
      add_item(32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
      add_item(32'shAAAA_AAAA, 32'sh5555_5555, 1'b1);
      // full store, then drops including the last item
      for (int i = 0; i < Capacity + 3; i++)
         add_item(i % 7, (i % 7) + 1 + (i % 3), i == Capacity + 2);
      while (pending_items.size() > 0 || expected_choices.size() > 0) @(posedge clock);
      hold_off = 1'b1;
      repeat (80) @(posedge clock);
      hold_off = 1'b0;
      // random sets, mostly small
      for (int k = 0; k < 12; k++) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
         mode = $urandom_range(0, 5);
         for (int i = 0; i < n; i++) begin
            if (mode <= 2) begin
               base = $urandom_range(0, 50);
               add_item(base, base + $urandom_range(0, 10), i == n - 1);
            end else begin
               add_item(rand_time(mode - 2), rand_time($urandom_range(0, 3)), i == n - 1);
            end
         end
      end
      while (pending_items.size() > 0 || expected_choices.size() > 0) @(posedge clock);
      repeat (Capacity + 10) @(posedge clock);
      $display("covered %0d interval sets, %0d chosen intervals, %0d sets with drops",
               sets_done, choices_seen, overflow_sets);
      if (mismatches == 0 && expected_choices.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/iss_pkg.sv
hw/rtl/iss_front.sv
hw/rtl/iss_back.sv
hw/rtl/interval_schedule_select_top.sv
sim/testbench.sv
